### hdl/mct_pkg.sv
`timescale 1ns / 1ps

package mct_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 32;
	localparam int DIST_W    = 9;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_SPARE  = 2'd3
	} act_t;

	// one table entry: stored value and its occurrence count
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
	} entry_t;

	// finished result handed from the sequencer to the output register
	typedef struct packed {
		logic              found;
		logic [CNT_W-1:0]  occurrences;
		logic [CNT_W-1:0]  total_items;
		logic [DIST_W-1:0] distinct_items;
		logic              is_empty;
		logic              overflow;
	} res_t;

endpackage

### hdl/multiset_count_table_core.sv
`timescale 1ns / 1ps

// counting multiset: a table of up to DEPTH distinct 32-bit values, each with
// an occurrence count, plus a running total of all counts
// input channel: in_valid / in_stall with action (add, remove, lookup) and
// elem_value; a transfer happens on a rising edge with in_valid high and
// in_stall low
// output channel: out_valid / out_stall with one result per input transfer
// (found, occurrences, total_items, distinct_items, is_empty, overflow)
// timing: one item at a time; in_stall is high from the cycle after a
// transfer until its result has moved into the output register
// an item is taken, the single compare unit then compares the table entries
// one by one (up to the number of occupied entries), the entry is updated,
// a remove that deletes an entry also reads the last entry and moves it
// into the hole, and the result is handed over; the linear search through
// the table memory dominates the time an item takes
// output register: the result waits there while out_stall is high, and the
// next item is already taken and searched; its result waits in the sequencer
// until the register frees
// reset: arst_n clears the entry count, the total and the sequencer; the
// table memory itself is not cleared, only occupied entries are ever used
module multiset_count_table_core import mct_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               action,
	input  logic signed [VAL_W-1:0]  elem_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic [CNT_W-1:0]         occurrences,
	output logic [CNT_W-1:0]         total_items,
	output logic [DIST_W-1:0]        distinct_items,
	output logic                     is_empty,
	output logic                     overflow
);

	// table address and entry count widths
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int UW = $clog2(DEPTH + 1);

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [IW-1:0] mem_raddr;
	entry_t        mem_rdata;

	logic          res_valid;
	res_t          res;
	logic          res_take;

	logic          out_valid_q;
	res_t          out_q;

	// value/count table, one write and one registered read a cycle
	mct_table #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// search / update sequencer around the shared compare unit
	mct_ctrl #(
		.DEPTH (DEPTH),
		.IW    (IW),
		.UW    (UW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.elem_value (elem_value),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	// output register is free when empty or when its result transfers now
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = out_q.found;
	assign occurrences    = out_q.occurrences;
	assign total_items    = out_q.total_items;
	assign distinct_items = out_q.distinct_items;
	assign is_empty       = out_q.is_empty;
	assign overflow       = out_q.overflow;

endmodule

### hdl/mct_table.sv
`timescale 1ns / 1ps

module mct_table import mct_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [IW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/mct_ctrl.sv
`timescale 1ns / 1ps

module mct_ctrl import mct_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int UW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       action,
	input  logic [VAL_W-1:0] elem_value,
	// table port
	output logic             mem_we,
	output logic [IW-1:0]    mem_waddr,
	output entry_t           mem_wdata,
	output logic [IW-1:0]    mem_raddr,
	input  entry_t           mem_rdata,
	// result handoff
	output logic             res_valid,
	output res_t             res,
	input  logic             res_take
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_MOVE = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t           state_q;
	logic [1:0]       act_q;
	logic [VAL_W-1:0] val_q;
	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    slot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] occ_q;
	logic             found_q;
	logic             ovf_q;
	logic [UW-1:0]    used_q;
	logic [CNT_W-1:0] total_q;

	logic             accept;
	logic             hit;
	logic             last;
	logic             total_full;
	logic             table_full;
	logic [CNT_W-1:0] cnt_next;

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign in_stall   = (state_q != ST_IDLE);
	// the one comparator, walked over the occupied entries
	assign hit        = (mem_rdata.value == val_q);
	assign last       = ((UW'(idx_q) + UW'(1)) == used_q);
	assign total_full = (total_q == '1);
	assign table_full = (used_q == UW'(DEPTH));
	// shared count incrementer / decrementer
	assign cnt_next   = (act_q == ACT_ADD) ? cnt_q + CNT_W'(1) : cnt_q - CNT_W'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '{value: val_q, count: cnt_next};
		case (state_q)
			ST_IDLE: mem_raddr = '0;
			ST_SCAN: mem_raddr = idx_q + IW'(1);
			ST_EXEC: mem_raddr = IW'(used_q - UW'(1));
			default: mem_raddr = '0;
		endcase
		case (state_q)
			ST_EXEC: begin
				if (act_q == ACT_ADD && !total_full) begin
					if (found_q) begin
						mem_we = 1'b1;
					end else if (!table_full) begin
						mem_we    = 1'b1;
						mem_waddr = IW'(used_q);
						mem_wdata = '{value: val_q, count: CNT_W'(1)};
					end
				end else if (act_q == ACT_REMOVE && found_q && cnt_q > CNT_W'(1)) begin
					mem_we = 1'b1;
				end
			end
			ST_MOVE: begin
				// last entry fills the hole
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			total_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (used_q == '0) ? ST_EXEC : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit || last) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					if (act_q == ACT_ADD) begin
						if (!total_full && (found_q || !table_full)) begin
							total_q <= total_q + CNT_W'(1);
							if (!found_q) begin
								used_q <= used_q + UW'(1);
							end
						end
					end else if (act_q == ACT_REMOVE && found_q) begin
						if (cnt_q > CNT_W'(1)) begin
							total_q <= total_q - CNT_W'(1);
						end else begin
							state_q <= ST_MOVE;
						end
					end
				end
				ST_MOVE: begin
					used_q  <= used_q - UW'(1);
					total_q <= total_q - CNT_W'(1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q   <= action;
				val_q   <= elem_value;
				idx_q   <= '0;
				found_q <= 1'b0;
				ovf_q   <= 1'b0;
			end
			ST_SCAN: begin
				if (hit) begin
					found_q <= 1'b1;
					slot_q  <= idx_q;
					cnt_q   <= mem_rdata.count;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			ST_EXEC: begin
				occ_q <= found_q ? cnt_q : '0;
				if (act_q == ACT_ADD) begin
					if (total_full) begin
						ovf_q <= 1'b1;
					end else if (found_q) begin
						occ_q <= cnt_next;
					end else if (table_full) begin
						ovf_q <= 1'b1;
					end else begin
						occ_q <= CNT_W'(1);
					end
				end else if (act_q == ACT_REMOVE && found_q) begin
					occ_q <= (cnt_q > CNT_W'(1)) ? cnt_next : '0;
				end
			end
			default: begin
				ovf_q <= ovf_q;
			end
		endcase
	end

	assign res_valid          = (state_q == ST_DONE);
	assign res.found          = found_q;
	assign res.occurrences    = occ_q;
	assign res.total_items    = total_q;
	assign res.distinct_items = DIST_W'(used_q);
	assign res.is_empty       = (used_q == '0);
	assign res.overflow       = ovf_q;

endmodule

### hdl/mct_checker.sv
`timescale 1ns / 1ps

module mct_checker import mct_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              found,
	input logic [CNT_W-1:0]  occurrences,
	input logic [CNT_W-1:0]  total_items,
	input logic [DIST_W-1:0] distinct_items,
	input logic              is_empty,
	input logic              overflow
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(total_items) && $stable(occurrences)
			&& $stable(found) && $stable(distinct_items) && $stable(is_empty)
			&& $stable(overflow))
		else $error("result payload changed while stalled");

	// the block is busy right after taking an item
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken before the first finished");

	// an empty table has no counts left
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> total_items == '0 && occurrences == '0
			&& distinct_items == '0)
		else $error("empty table reports nonzero counts");

	// an absent value ends with at most one occurrence
	a_absent_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> occurrences <= CNT_W'(1))
		else $error("absent value reports more than one occurrence");

endmodule

bind multiset_count_table_core mct_checker u_mct_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mct_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int POOL_SIZE    = 16;
	localparam int HOLD_CYCLES  = 1500;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int REPORT_LINES = 100;

	// block ports; the inputs are known from time zero
	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic                    in_stall;
	logic [1:0]              action     = ACT_LOOKUP;
	logic signed [VAL_W-1:0] elem_value = '0;
	logic                    out_valid;
	logic                    out_stall  = 1'b0;
	logic                    found;
	logic [CNT_W-1:0]        occurrences;
	logic [CNT_W-1:0]        total_items;
	logic [DIST_W-1:0]       distinct_items;
	logic                    is_empty;
	logic                    overflow;

	// shadow copy of the table, advanced once per accepted transfer
	logic [VAL_W-1:0] shadow_value [DEPTH];
	logic [CNT_W-1:0] shadow_count [DEPTH];
	int               shadow_used  = 0;
	logic [CNT_W-1:0] shadow_total = '0;

	// results still owed by the block, oldest first
	res_t pending_results [$];

	logic [VAL_W-1:0] value_pool [POOL_SIZE];
	int               sender_idle_pct = 0;
	int               sink_idle_pct   = 0;
	logic             holding         = 1'b0;
	event             hold_go;
	int               error_count     = 0;
	int               checked_count   = 0;
	int               cycle_count     = 0;

	multiset_count_table_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.elem_value(elem_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.occurrences(occurrences),
		.total_items(total_items),
		.distinct_items(distinct_items),
		.is_empty(is_empty),
		.overflow(overflow)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		// keep the log short when something goes badly wrong
		if (error_count <= REPORT_LINES)
			$display("[%0t] %s", $time, msg);
	endtask

	// slot holding val in the shadow table, -1 when absent
	function automatic int shadow_find(input logic [VAL_W-1:0] val);
		for (int i = 0; i < shadow_used; i++)
			if (shadow_value[i] == val)
				return i;
		return -1;
	endfunction

	// one step of the counting table: updates the shadow state, returns the result
	function automatic res_t shadow_step(input logic [1:0] act, input logic [VAL_W-1:0] val);
		res_t             r;
		int               slot;
		int               last;
		logic [CNT_W-1:0] occ;
		logic             ovf;
		slot = shadow_find(val);
		occ  = (slot >= 0) ? shadow_count[slot] : '0;
		ovf  = 1'b0;
		case (act)
			ACT_ADD: begin
				// a full total also covers every count that could saturate
				if (shadow_total == '1) begin
					ovf = 1'b1;
				end else if (slot >= 0) begin
					occ                = occ + 1;
					shadow_count[slot] = occ;
					shadow_total++;
				end else if (shadow_used >= DEPTH) begin
					ovf = 1'b1;
				end else begin
					shadow_value[shadow_used] = val;
					shadow_count[shadow_used] = 1;
					shadow_used++;
					occ = 1;
					shadow_total++;
				end
			end
			ACT_REMOVE: begin
				if (slot >= 0) begin
					if (occ > 1) begin
						occ                = occ - 1;
						shadow_count[slot] = occ;
					end else begin
						// last occupied entry moves into the hole
						last               = shadow_used - 1;
						shadow_value[slot] = shadow_value[last];
						shadow_count[slot] = shadow_count[last];
						shadow_used        = last;
						occ                = '0;
					end
					shadow_total--;
				end
			end
			// lookup and the spare code leave the table alone
			default: ;
		endcase
		r.found          = (slot >= 0);
		r.occurrences    = occ;
		r.total_items    = shadow_total;
		r.distinct_items = DIST_W'(shadow_used);
		r.is_empty       = (shadow_used == 0);
		r.overflow       = ovf;
		return r;
	endfunction

	// random gap before the next transfer; lengths vary so gaps land in every
	// phase of the search
	task automatic sender_pause();
		int n;
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// offer one item, hold it steady until the transfer, then predict its result
	task automatic send_item(input logic [1:0] act, input logic [VAL_W-1:0] val);
		sender_pause();
		in_valid   <= 1'b1;
		action     <= act;
		elem_value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(shadow_step(act, val));
	endtask

	// values from the table, from the recurring pool (most often) and some fresh ones
	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 25 && shadow_used > 0)
			return shadow_value[$urandom_range(shadow_used - 1)];
		if (r < 85)
			return value_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_action();
		int r;
		r = $urandom_range(99);
		// lean toward removes once the table grows so searches stay short
		if (shadow_used > 40 && r < 60)
			return ACT_REMOVE;
		if (r < 45)
			return ACT_ADD;
		if (r < 80)
			return ACT_REMOVE;
		if (r < 95)
			return ACT_LOOKUP;
		return ACT_SPARE;
	endfunction

	// a value not in the table yet
	function automatic logic [VAL_W-1:0] fresh_value();
		logic [VAL_W-1:0] v;
		do v = $urandom; while (shadow_find(v) >= 0);
		return v;
	endfunction

	task automatic run_random(input int n_items);
		for (int i = 0; i < n_items; i++)
			send_item(pick_action(), pick_value());
	endtask

	// extremes of the value, every action, deletes at first and last slot
	task automatic test_directed();
		sender_idle_pct = 30;
		sink_idle_pct   = 30;
		send_item(ACT_LOOKUP, 32'h0000_0000);    // lookup on empty table
		send_item(ACT_REMOVE, 32'h0000_0005);    // remove from empty table
		send_item(ACT_ADD,    32'h8000_0000);
		send_item(ACT_ADD,    32'h7fff_ffff);
		send_item(ACT_ADD,    32'h7fff_ffff);    // second occurrence
		send_item(ACT_ADD,    32'h0000_0000);
		send_item(ACT_ADD,    32'hffff_ffff);
		send_item(ACT_LOOKUP, 32'h7fff_ffff);
		send_item(ACT_SPARE,  32'hffff_ffff);    // spare code acts as lookup
		send_item(ACT_REMOVE, 32'h7fff_ffff);    // count drops, entry stays
		send_item(ACT_REMOVE, 32'h1234_5678);    // absent value, table not empty
		send_item(ACT_REMOVE, 32'h8000_0000);    // delete first slot, last moves in
		send_item(ACT_LOOKUP, 32'hffff_ffff);    // moved entry still found
		send_item(ACT_REMOVE, 32'hffff_ffff);
		send_item(ACT_ADD,    32'h5555_5555);
		send_item(ACT_REMOVE, 32'h5555_5555);    // delete the last slot itself
		send_item(ACT_REMOVE, 32'h0000_0000);
		send_item(ACT_REMOVE, 32'h7fff_ffff);    // table empty again
		send_item(ACT_LOOKUP, 32'h7fff_ffff);
		send_item(ACT_ADD,    32'haaaa_aaaa);
		send_item(ACT_SPARE,  32'haaaa_aaaa);
		send_item(ACT_REMOVE, 32'haaaa_aaaa);
	endtask

	// fill every slot, hit the full-table rejection, then drain in random order
	task automatic test_table_full();
		int j;
		sender_idle_pct = 30;
		sink_idle_pct   = 30;
		while (shadow_used < DEPTH)
			send_item(ACT_ADD, fresh_value());
		send_item(ACT_ADD, fresh_value());                   // rejected, table full
		send_item(ACT_ADD, shadow_value[0]);                 // existing value still counts up
		send_item(ACT_LOOKUP, fresh_value());
		j = $urandom_range(1, DEPTH - 1);
		send_item(ACT_REMOVE, shadow_value[j]);              // frees one slot
		send_item(ACT_ADD, fresh_value());                   // fits again
		send_item(ACT_ADD, fresh_value());                   // rejected again
		while (shadow_used > 0) begin
			j = $urandom_range(9);
			if (j < 8)
				send_item(ACT_REMOVE, shadow_value[$urandom_range(shadow_used - 1)]);
			else if (j == 8)
				send_item(ACT_LOOKUP, pick_value());
			else
				send_item(ACT_ADD, shadow_value[$urandom_range(shadow_used - 1)]);
		end
	endtask

	// back to back with no idling on either side
	task automatic test_random_steady();
		sender_idle_pct = 0;
		sink_idle_pct   = 0;
		run_random(80);
	endtask

	task automatic test_random_gaps();
		sender_idle_pct = 30;
		sink_idle_pct   = 30;
		run_random(50);
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_backpressure();
		sender_idle_pct = 0;
		sink_idle_pct   = 0;
		-> hold_go;
		run_random(16);
	endtask

	// long receiver hold-off, counted here
	initial begin
		forever begin
			@(hold_go);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	task automatic check_result();
		res_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing pending", checked_count));
		end else begin
			want = pending_results.pop_front();
			if (found !== want.found)
				report_mismatch($sformatf("result %0d found: got %0b expected %0b",
					checked_count, found, want.found));
			if (occurrences !== want.occurrences)
				report_mismatch($sformatf("result %0d occurrences: got %0d expected %0d",
					checked_count, occurrences, want.occurrences));
			if (total_items !== want.total_items)
				report_mismatch($sformatf("result %0d total_items: got %0d expected %0d",
					checked_count, total_items, want.total_items));
			if (distinct_items !== want.distinct_items)
				report_mismatch($sformatf("result %0d distinct_items: got %0d expected %0d",
					checked_count, distinct_items, want.distinct_items));
			if (is_empty !== want.is_empty)
				report_mismatch($sformatf("result %0d is_empty: got %0b expected %0b",
					checked_count, is_empty, want.is_empty));
			if (overflow !== want.overflow)
				report_mismatch($sformatf("result %0d overflow: got %0b expected %0b",
					checked_count, overflow, want.overflow));
		end
		checked_count++;
	endtask

	// result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		out_stall <= holding || (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct);
	end

	initial begin
		// pool of values that recur, extremes included
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'h0000_0001;
		value_pool[2] = 32'hffff_ffff;
		value_pool[3] = 32'h8000_0000;
		value_pool[4] = 32'h7fff_ffff;
		for (int i = 5; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_steady();
		test_backpressure();
		test_table_full();
		test_random_gaps();

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// room for a stray extra result to show up
		repeat (DEPTH + 8) @(posedge clk);

		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", error_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/mct_pkg.sv
hdl/mct_table.sv
hdl/mct_ctrl.sv
hdl/multiset_count_table_core.sv
hdl/mct_checker.sv
tb/sv/tb_top.sv
